// ===== hdl/dlf_pkg.sv =====
// Shared types and constants for the line-drawing character framebuffer.
// Used by dlf_shared_unit and dda_line_framebuffer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dlf_pkg;

	typedef enum logic [1:0] {
		OP_DRAW  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic {
		MODE_ROOT = 1'b0,
		MODE_DIV  = 1'b1
	} unit_mode_t;

	typedef struct packed {
		logic       start;
		unit_mode_t mode;
	} unit_req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_RESP,
		ST_SQ_A,
		ST_SQ_B,
		ST_ROOT,
		ST_ROOT_WAIT,
		ST_SIZE,
		ST_MUL,
		ST_DIV,
		ST_DIV_WAIT,
		ST_FIX,
		ST_WALK
	} state_t;

	localparam int ROOT_STEPS = 32;
	localparam int DIV_STEPS  = 48;
	localparam int DIVISOR_W  = 38;
	localparam int REM_W      = 40;
	localparam int QUO_W      = 48;
	localparam int CNT_W      = 11;
	localparam logic [7:0] RESET_GLYPH = 8'd32;

endpackage
`default_nettype wire

// ===== hdl/dlf_shared_unit.sv =====
// Shared iterative unit: integer square root (two bits a step) or restoring
// division (one bit a step) over one subtractor. Depends on dlf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dlf_shared_unit import dlf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire unit_req_t            req,
	input  wire logic [63:0]          operand,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      done,
	output logic [QUO_W-1:0]          result,
	output logic [REM_W-1:0]          remainder
);

	logic                 busy_q;
	logic                 done_q;
	unit_mode_t           mode_q;
	logic [5:0]           step_q;
	logic [63:0]          acc_q;
	logic [QUO_W-1:0]     res_q;
	logic [REM_W-1:0]     rem_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [REM_W-1:0]     rem_sh;
	logic [REM_W-1:0]     trial;
	logic [REM_W:0]       diff;
	logic                 ge;

	always_comb begin
		unique case (mode_q)
			MODE_ROOT: begin
				rem_sh = {rem_q[REM_W-3:0], acc_q[63:62]};
				trial  = {4'b0, res_q[33:0], 2'b01};
			end
			MODE_DIV: begin
				rem_sh = {rem_q[REM_W-2:0], acc_q[47]};
				trial  = {2'b0, div_q};
			end
		endcase
		diff = {1'b0, rem_sh} - {1'b0, trial};
		ge   = !diff[REM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && busy_q && (step_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			step_q <= (req.mode == MODE_ROOT) ? 6'(ROOT_STEPS) : 6'(DIV_STEPS);
			acc_q  <= operand;
			res_q  <= '0;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			step_q <= step_q - 6'd1;
			acc_q  <= (mode_q == MODE_ROOT) ? {acc_q[61:0], 2'b00} : {acc_q[62:0], 1'b0};
			res_q  <= {res_q[QUO_W-2:0], ge};
			rem_q  <= ge ? diff[REM_W-1:0] : rem_sh;
		end
	end

	assign done      = done_q;
	assign result    = res_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== hdl/dda_line_framebuffer.sv =====
// Top level of the character framebuffer with line drawer: sequencer, line
// walker and cell memory. Depends on dlf_pkg and dlf_shared_unit.
//
// Usage. One input channel (in_valid / in_stall) carries a word with an op:
// draw a line, read a cell or clear the whole store. Only a read produces an
// output word on out_valid / out_stall, carrying cell_glyph. One word is
// worked on at a time; in_stall is high whenever the sequencer is busy.
// A read passes through ST_RD and ST_RESP, and its result is registered into
// the output register in the same cycle as the input is freed again.
// A clear writes the clear glyph into every cell in turn. A draw first runs
// a square root and four divisions on the shared iterative unit as setup
// and then walks its points in ST_WALK. Points are walked with an exact
// running quotient and remainder, so the walk needs no divider.
// At reset the clear glyph becomes 32 and a clearing pass fills the store;
// input is stalled while it runs, configuration writes are still taken. If
// the receiver stalls a read result, the result is held in the output
// register and the block goes on taking words; a later read waits with its
// result until the held word has been taken.
`timescale 1ns / 1ps
`default_nettype none
module dda_line_framebuffer import dlf_pkg::*; #(
	parameter int GRID_ROWS    = 128,
	parameter int GRID_COLUMNS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [15:0] end_x,
	input  wire logic signed [15:0] end_y,
	input  wire logic [7:0]         glyph,
	input  wire logic [6:0]         read_row,
	input  wire logic [7:0]         read_col,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              cell_glyph
);

	localparam int CELLS = GRID_ROWS * GRID_COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam logic signed [16:0] COLS_S   = 17'(GRID_COLUMNS);
	localparam logic signed [16:0] ROWS_S   = 17'(GRID_ROWS);
	localparam logic signed [16:0] COL_HALF = 17'(GRID_COLUMNS / 2);
	localparam logic signed [16:0] ROW_HALF = 17'(GRID_ROWS / 2);

	// Control state.
	state_t          state_q, state_n;
	logic [AW-1:0]   clr_addr_q;
	logic [7:0]      clear_glyph_q;
	logic [7:0]      clr_val_q;
	logic            wr_en_s1;
	logic            out_valid_q;
	logic [1:0]      phase_q;
	logic [CNT_W-1:0] cnt_q;

	// Datapath.
	logic [AW-1:0]          wr_addr_s1;
	logic [7:0]             wr_data_s1;
	logic [AW-1:0]          rd_addr_q;
	logic                   rd_off_q;
	logic [7:0]             rd_data_q;
	logic [7:0]             cell_glyph_q;
	logic signed [15:0]     sx_q, sy_q;
	logic signed [16:0]     dx_q, dy_q;
	logic [7:0]             glyph_q;
	logic [33:0]            sq_q;
	logic [33:0]            d_q;
	logic [31:0]            r_q;
	logic signed [48:0]     num_q;
	logic signed [15:0]     qx_q, qy_q, qsx_q, qsy_q;
	logic [DIVISOR_W-1:0]   remx_q, remy_q, rsx_q, rsy_q;

	logic [7:0] mem [CELLS];

	// Shared unit.
	unit_req_t        ureq;
	logic             udone;
	logic [QUO_W-1:0] ures;
	logic [REM_W-1:0] urem;
	logic [63:0]      uop;
	logic [DIVISOR_W-1:0] dv;

	logic accept;
	logic out_free;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign dv       = {r_q, 6'b0};

	// The unit divides a magnitude; num_q never reaches 2^47 in magnitude.
	always_comb begin
		if (state_q == ST_ROOT) begin
			uop = {d_q, 30'b0};
		end else begin
			uop = {16'b0, (num_q < 0) ? 48'(-num_q) : 48'(num_q)};
		end
	end

	dlf_shared_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ureq),
		.operand  (uop),
		.divisor  (dv),
		.done     (udone),
		.result   (ures),
		.remainder(urem)
	);

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(CELLS - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_DRAW:  state_n = ST_SQ_A;
						OP_READ:  state_n = ST_RD;
						OP_CLEAR: state_n = ST_CLEAR;
						default:  state_n = ST_IDLE;
					endcase
				end
			end
			ST_RD:        state_n = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			ST_SQ_A:      state_n = ST_SQ_B;
			ST_SQ_B:      state_n = ST_ROOT;
			ST_ROOT:      state_n = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (udone) begin
					state_n = ST_SIZE;
				end
			end
			ST_SIZE:      state_n = ST_MUL;
			ST_MUL:       state_n = ST_DIV;
			ST_DIV:       state_n = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (udone) begin
					state_n = ST_FIX;
				end
			end
			ST_FIX:       state_n = (phase_q == 2'd3) ? ST_WALK : ST_MUL;
			ST_WALK: begin
				if (cnt_q == CNT_W'(1)) begin
					state_n = ST_IDLE;
				end
			end
		endcase
	end

	// Control outputs.
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		ureq.start = (state_q == ST_ROOT) || (state_q == ST_DIV);
		ureq.mode  = (state_q == ST_ROOT) ? MODE_ROOT : MODE_DIV;
	end

	// Walk arithmetic: each coordinate is kept as floor quotient and
	// remainder against 64*R; truncation toward zero bumps a negative
	// quotient with a nonzero remainder.
	logic signed [15:0] tx, ty;
	logic signed [16:0] col_w, row_w;
	logic               in_grid;
	logic [DIVISOR_W:0] sumx, sumy;
	logic               wrapx, wrapy;

	always_comb begin
		tx      = qx_q + 16'((qx_q < 0) && (remx_q != '0));
		ty      = qy_q + 16'((qy_q < 0) && (remy_q != '0));
		col_w   = 17'(tx) + COL_HALF;
		row_w   = 17'(ty) + ROW_HALF;
		in_grid = (col_w >= 0) && (col_w < COLS_S) && (row_w >= 0) && (row_w < ROWS_S);
		sumx    = {1'b0, remx_q} + {1'b0, rsx_q};
		sumy    = {1'b0, remy_q} + {1'b0, rsy_q};
		wrapx   = sumx >= {1'b0, dv};
		wrapy   = sumy >= {1'b0, dv};
	end

	// Floor fix-up of the unit's magnitude quotient and remainder.
	logic signed [15:0]   fq;
	logic [DIVISOR_W-1:0] fr;
	logic                 ra_nz;

	always_comb begin
		ra_nz = (urem[DIVISOR_W-1:0] != '0);
		if (num_q < 0) begin
			fq = -$signed(ures[15:0]) - 16'(ra_nz);
			fr = ra_nz ? dv - urem[DIVISOR_W-1:0] : '0;
		end else begin
			fq = $signed(ures[15:0]);
			fr = urem[DIVISOR_W-1:0];
		end
	end

	// Sizing of the walk.
	logic [17:0] m_w;
	logic [17:0] n_w;

	always_comb begin
		m_w = (d_q == '0) ? 18'd0 : 18'(ures[31:15]) + 18'(urem != '0);
		n_w = (m_w + 18'd63) >> 6;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			clear_glyph_q <= RESET_GLYPH;
			clr_val_q     <= RESET_GLYPH;
			wr_en_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_wr_en) begin
				clear_glyph_q <= cfg_wr_data;
			end
			wr_en_s1 <= (state_q == ST_CLEAR) || ((state_q == ST_WALK) && in_grid);
			if (accept && op_t'(op) == OP_CLEAR) begin
				clr_addr_q <= '0;
				clr_val_q  <= clear_glyph_q;
			end else if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q      <= start_x;
			sy_q      <= start_y;
			dx_q      <= 17'(end_x) - 17'(start_x);
			dy_q      <= 17'(end_y) - 17'(start_y);
			glyph_q   <= glyph;
			rd_off_q  <= !((32'(read_row) < 32'(GRID_ROWS)) && (32'(read_col) < 32'(GRID_COLUMNS)));
			rd_addr_q <= AW'(32'(read_row) * 32'(GRID_COLUMNS) + 32'(read_col));
		end
		if (state_q == ST_CLEAR) begin
			wr_addr_s1 <= clr_addr_q;
			wr_data_s1 <= clr_val_q;
		end else begin
			wr_addr_s1 <= AW'(32'(row_w) * 32'(GRID_COLUMNS) + 32'(col_w));
			wr_data_s1 <= glyph_q;
		end
		if (state_q == ST_RESP && out_free) begin
			cell_glyph_q <= rd_off_q ? 8'd0 : rd_data_q;
		end
		unique case (state_q)
			ST_SQ_A: sq_q <= 34'(dx_q * dx_q);
			ST_SQ_B: d_q  <= sq_q + 34'(dy_q * dy_q);
			ST_SIZE: begin
				r_q     <= (d_q == '0) ? 32'd1 : ures[31:0];
				cnt_q   <= (n_w == '0) ? CNT_W'(1) : CNT_W'(n_w);
				phase_q <= 2'd0;
			end
			ST_MUL: begin
				unique case (phase_q)
					2'd0: num_q <= 49'(sx_q * $signed({1'b0, r_q}));
					2'd1: num_q <= 49'(sy_q * $signed({1'b0, r_q}));
					2'd2: num_q <= 49'(dx_q) <<< 21;
					2'd3: num_q <= 49'(dy_q) <<< 21;
				endcase
			end
			ST_FIX: begin
				unique case (phase_q)
					2'd0: begin qx_q  <= fq; remx_q <= fr; end
					2'd1: begin qy_q  <= fq; remy_q <= fr; end
					2'd2: begin qsx_q <= fq; rsx_q  <= fr; end
					2'd3: begin qsy_q <= fq; rsy_q  <= fr; end
				endcase
				phase_q <= phase_q + 2'd1;
			end
			ST_WALK: begin
				cnt_q  <= cnt_q - CNT_W'(1);
				qx_q   <= qx_q + qsx_q + 16'(wrapx);
				qy_q   <= qy_q + qsy_q + 16'(wrapy);
				remx_q <= wrapx ? DIVISOR_W'(sumx - {1'b0, dv}) : sumx[DIVISOR_W-1:0];
				remy_q <= wrapy ? DIVISOR_W'(sumy - {1'b0, dv}) : sumy[DIVISOR_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Cell memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[wr_addr_s1] <= wr_data_s1;
		end
		rd_data_q <= mem[rd_addr_q];
	end

	assign out_valid  = out_valid_q;
	assign cell_glyph = cell_glyph_q;

endmodule
`default_nettype wire

// ===== tb/dda_line_framebuffer_checker.sv =====
// Checker for the line-drawing character framebuffer: watches both channels
// and the configuration port, keeps its own copy of the cell store and
// predicts every read result. Depends on dlf_pkg.
`timescale 1ns / 1ps
module dda_line_framebuffer_checker import dlf_pkg::*; #(
	parameter int GRID_ROWS    = 128,
	parameter int GRID_COLUMNS = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [7:0]         cfg_wr_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [1:0]         op,
	input  wire logic signed [15:0] start_x,
	input  wire logic signed [15:0] start_y,
	input  wire logic signed [15:0] end_x,
	input  wire logic signed [15:0] end_y,
	input  wire logic [7:0]         glyph,
	input  wire logic [6:0]         read_row,
	input  wire logic [7:0]         read_col,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [7:0]         cell_glyph,
	output int                      fail_count,
	output int                      pending
);

	localparam int CELLS = GRID_ROWS * GRID_COLUMNS;

	logic [7:0] cell_copy [CELLS];
	logic [7:0] blank_glyph;
	logic [7:0] glyph_queue [$];

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic plot_cell(longint x, longint y, logic [7:0] g);
		longint col;
		longint row;
		col = x + GRID_COLUMNS / 2;
		row = y + GRID_ROWS / 2;
		if (col >= 0 && col < GRID_COLUMNS && row >= 0 && row < GRID_ROWS)
			cell_copy[row * GRID_COLUMNS + col] = g;
	endtask

	task automatic fill_cells(logic [7:0] g);
		for (int k = 0; k < CELLS; k++)
			cell_copy[k] = g;
	endtask

	// Appends one expected read result at the tail of the queue.
	task automatic expect_word(logic [7:0] g);
		glyph_queue.insert(glyph_queue.size(), g);
	endtask

	// One point per 64 units of length (one cell) from the start; each
	// coordinate is an exact quotient truncated toward zero.
	task automatic trace_line(longint sx, longint sy, longint ex, longint ey,
			logic [7:0] g);
		longint dx;
		longint dy;
		longint r;
		longint unsigned d;
		longint unsigned s;
		longint unsigned m;
		longint unsigned n;
		dx = ex - sx;
		dy = ey - sy;
		d = longint'(dx * dx) + longint'(dy * dy);
		if (d == 0) begin
			plot_cell(sx / 64, sy / 64, g);
			return;
		end
		s = int_root(d);
		m = (s * s == d) ? s : s + 1;
		n = (m + 63) / 64;
		if (n == 0)
			n = 1;
		r = longint'(int_root(d << 30));
		if (r <= 0)
			r = 1;
		for (longint i = 0; i < longint'(n); i++)
			plot_cell((sx * r + i * dx * 2097152) / (64 * r),
				(sy * r + i * dy * 2097152) / (64 * r), g);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_glyph = RESET_GLYPH;
			fill_cells(RESET_GLYPH);
			glyph_queue.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (glyph_queue.size() == 0) begin
					$error("cell_glyph: unexpected word, actual %0d", cell_glyph);
					fail_count++;
				end else if (cell_glyph !== glyph_queue[0]) begin
					$error("cell_glyph: expected %0d, actual %0d",
						glyph_queue[0], cell_glyph);
					fail_count++;
					void'(glyph_queue.pop_front());
				end else begin
					void'(glyph_queue.pop_front());
				end
			end
			if (cfg_wr_en)
				blank_glyph = cfg_wr_data;
			if (in_valid && !in_stall) begin
				case (op)
					OP_DRAW:
						trace_line(start_x, start_y, end_x, end_y, glyph);
					OP_READ:
						if (read_row < GRID_ROWS && read_col < GRID_COLUMNS)
							expect_word(
								cell_copy[read_row * GRID_COLUMNS + read_col]);
						else
							expect_word(8'd0);
					OP_CLEAR:
						fill_cells(blank_glyph);
					default: ;
				endcase
			end
			pending = glyph_queue.size();
		end
	end

endmodule

// ===== tb/dda_line_framebuffer_tb.sv =====
// Top of the framebuffer testbench: clock, reset, stimulus and verdict.
// Depends on dlf_pkg, dda_line_framebuffer and dda_line_framebuffer_checker.
`timescale 1ns / 1ps
module dda_line_framebuffer_tb import dlf_pkg::*; ;

	localparam int ROWS = 128;
	localparam int COLS = 256;
	// The one op code the block must ignore.
	localparam logic [1:0] OP_SPARE = 2'd3;
	// A generous bound, far above the length of the slowest correct run.
	localparam int CYCLE_LIMIT = 4000000;
	localparam int WORDS_PER_PHASE = 500;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [7:0]         cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic [7:0]         glyph;
	logic [6:0]         read_row;
	logic [7:0]         read_col;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         cell_glyph;
	int                 fail_count;
	int                 pending;
	int                 tx_idle_pct;
	int                 rx_idle_pct;
	int                 cycles;
	// Cell of the most recent line start, so that reads land where drawing was.
	int                 recent_row;
	int                 recent_col;

	dda_line_framebuffer #(.GRID_ROWS(ROWS), .GRID_COLUMNS(COLS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .glyph(glyph),
		.read_row(read_row), .read_col(read_col),
		.out_valid(out_valid), .out_stall(out_stall), .cell_glyph(cell_glyph)
	);

	dda_line_framebuffer_checker #(.GRID_ROWS(ROWS), .GRID_COLUMNS(COLS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .glyph(glyph),
		.read_row(read_row), .read_col(read_col),
		.out_valid(out_valid), .out_stall(out_stall), .cell_glyph(cell_glyph),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dda_line_framebuffer_tb NOT OK");
			$finish;
		end
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk)
		out_stall = ($urandom_range(99) < rx_idle_pct);

	// Offers one word and holds it until it is taken. Afterwards the sender
	// may drop valid for a random pause; otherwise valid stays high for the next
	// word, which the caller drives in this same time step.
	task automatic send_word(logic [1:0] o, logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] ex, logic signed [15:0] ey, logic [7:0] g,
			logic [6:0] rr, logic [7:0] rc);
		in_valid = 1'b1;
		op = o;
		start_x = sx;
		start_y = sy;
		end_x = ex;
		end_y = ey;
		glyph = g;
		read_row = rr;
		read_col = rc;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic draw(int sx, int sy, int ex, int ey, logic [7:0] g);
		send_word(OP_DRAW, 16'(sx), 16'(sy), 16'(ex), 16'(ey), g,
			7'($urandom), 8'($urandom));
		recent_row = sy / 64 + ROWS / 2;
		recent_col = sx / 64 + COLS / 2;
	endtask

	task automatic read_cell(int rr, int rc);
		send_word(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			8'($urandom), 7'(rr), 8'(rc));
	endtask

	// Waits until every read has been answered and the sequencer has gone
	// quiet, since a draw or a clear may still be running after that.
	task automatic drain;
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		while (in_stall)
			@(negedge clk);
	endtask

	task automatic write_blank_glyph(logic [7:0] g);
		cfg_wr_en = 1'b1;
		cfg_wr_data = g;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'($urandom);
	endtask

	// Mostly lines within or just around the grid, with vertical, zero-length,
	// short and full-range lines mixed in.
	task automatic random_draw;
		int sx;
		int sy;
		int ex;
		int ey;
		int shape;
		shape = $urandom_range(9);
		sx = $urandom_range(0, COLS * 64 + 400) - (COLS * 32 + 200);
		sy = $urandom_range(0, ROWS * 64 + 400) - (ROWS * 32 + 200);
		ex = $urandom_range(0, COLS * 64 + 400) - (COLS * 32 + 200);
		ey = $urandom_range(0, ROWS * 64 + 400) - (ROWS * 32 + 200);
		case (shape)
			6: ex = sx;
			7: begin
				ex = sx;
				ey = sy;
			end
			8: begin
				sx = $signed(16'($urandom));
				sy = $signed(16'($urandom));
				ex = $signed(16'($urandom));
				ey = $signed(16'($urandom));
			end
			9: begin
				ex = sx + $urandom_range(0, 512) - 256;
				ey = sy + $urandom_range(0, 512) - 256;
			end
			default: ;
		endcase
		draw(sx, sy, ex, ey, 8'($urandom));
	endtask

	task automatic random_read;
		int rr;
		int rc;
		if ($urandom_range(3) == 0) begin
			rr = $urandom_range(ROWS - 1);
			rc = $urandom_range(COLS - 1);
		end else begin
			rr = recent_row + $urandom_range(0, 4) - 2;
			rc = recent_col + $urandom_range(0, 4) - 2;
			rr = (rr < 0) ? 0 : (rr > ROWS - 1) ? ROWS - 1 : rr;
			rc = (rc < 0) ? 0 : (rc > COLS - 1) ? COLS - 1 : rc;
		end
		read_cell(rr, rc);
	endtask

	task automatic random_phase(bit with_pause);
		int sent;
		int pick;
		sent = 0;
		while (sent < WORDS_PER_PHASE) begin
			pick = $urandom_range(999);
			if (pick < 450) begin
				random_draw();
				sent++;
			end else if (pick < 930) begin
				random_read();
				sent++;
			end else if (pick < 934) begin
				send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
				sent++;
			end else begin
				send_word(OP_SPARE, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom), 7'($urandom), 8'($urandom));
			end
			// With a pause, the sender stops half-way until every read is answered.
			if (with_pause && sent == WORDS_PER_PHASE / 2) begin
				in_valid = 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		in_valid = 1'b0;
		op = OP_DRAW;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		glyph = '0;
		read_row = '0;
		read_col = '0;
		out_stall = 1'b0;
		tx_idle_pct = 10;
		rx_idle_pct = 58;
		recent_row = ROWS / 2;
		recent_col = COLS / 2;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// The clearing pass after reset fills the store with the reset glyph;
		// the bench lets it finish before the register is touched.
		repeat (ROWS * COLS + 100) @(negedge clk);
		while (in_stall)
			@(negedge clk);

		// Directed words. Reset contents first, then edge cases of the walker.
		read_cell(0, 0);
		read_cell(ROWS - 1, COLS - 1);
		drain();
		write_blank_glyph(8'd0);
		draw(0, 0, 0, 0, 8'hFF);
		read_cell(ROWS / 2, COLS / 2);
		// Either side of -64: truncation toward zero puts x = -65 in column -1
		// and y = -63 in row 0, the centre cell's left neighbour.
		draw(-65, -63, -65, -63, 8'h00);
		read_cell(ROWS / 2, COLS / 2 - 1);
		draw(300, -2000, 300, 2000, 8'h41);
		read_cell(ROWS / 2 + 10, COLS / 2 + 4);
		draw(-5000, 700, 5000, 700, 8'h42);
		read_cell(ROWS / 2 + 10, COLS / 2);
		draw(-32768, -32768, 32767, 32767, 8'h5A);
		read_cell(ROWS / 2, COLS / 2);
		draw(32767, -32768, -32768, 32767, 8'hA5);
		draw(20000, 20000, 25000, 21000, 8'h7E);
		draw(-8192, -4096, 8191, 4095, 8'h23);
		read_cell(0, 0);
		send_word(OP_SPARE, 16'sh7FFF, 16'sh8000, '0, '0, 8'hEE, 7'd64, 8'd128);
		read_cell(ROWS / 2, COLS / 2);
		send_word(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0);
		read_cell(ROWS / 2, COLS / 2);
		read_cell(ROWS - 1, 0);

		random_phase(1'b0);
		drain();
		write_blank_glyph(8'hFF);
		tx_idle_pct = 58;
		rx_idle_pct = 10;
		random_phase(1'b1);
		drain();
		write_blank_glyph(8'($urandom));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_phase(1'b0);

		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2000) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("dda_line_framebuffer_tb OK");
		else
			$display("dda_line_framebuffer_tb NOT OK");
		$finish;
	end

endmodule
